FILE: design/mets_pkg.sv
// ----------------------------------------------------------------------------
// mets_pkg
// Shared widths, constants, types and functions for the escape-time pixel
// evaluator.
// ----------------------------------------------------------------------------
package mets_pkg;

   localparam int FRAC_BITS    = 44;
   localparam int INT_BITS     = 4;
   localparam int COORD_WIDTH  = FRAC_BITS + INT_BITS;
   localparam int ITER_BITS    = 12;
   localparam int PIXEL_WIDTH  = 16;
   localparam int OFFSET_WIDTH = 32;
   localparam int STEP_WIDTH   = 45;
   localparam int DIFF_WIDTH   = OFFSET_WIDTH + 1;

   localparam int MAG_MIN_A    = (COORD_WIDTH > STEP_WIDTH) ? COORD_WIDTH : STEP_WIDTH;
   localparam int MAG_MIN      = (MAG_MIN_A > DIFF_WIDTH) ? MAG_MIN_A : DIFF_WIDTH;
   localparam int CHUNK_WIDTH  = (MAG_MIN + 1) / 2;
   localparam int MAG_WIDTH    = 2 * CHUNK_WIDTH;
   localparam int PROD_WIDTH   = 2 * MAG_WIDTH;
   localparam int PP_WIDTH     = 2 * CHUNK_WIDTH;

   // square of a saturated coordinate after the fraction shift
   localparam int SQ_WIDTH     = 2 * COORD_WIDTH - 1 - FRAC_BITS;
   localparam int CROSS_WIDTH  = SQ_WIDTH + 1;
   localparam int SUM_WIDTH    = SQ_WIDTH + 3;
   localparam int ESC_WIDTH    = SQ_WIDTH + 1;

   localparam int MUL_STEPS      = 4;
   localparam int MUL_STEP_WIDTH = 3;
   localparam int SHIFT_SEL_WIDTH = 2;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = STEP_WIDTH;

   localparam int COLOR_WIDTH = 8;
   localparam int RGB_WIDTH   = 3 * COLOR_WIDTH;
   localparam int PAL_BAND    = 1 << COLOR_WIDTH;
   localparam int BAND_WIDTH  = ITER_BITS + 1 - COLOR_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_X       = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_Y       = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXEL_STEP     = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ITERATIONS = CSR_INDEX_WIDTH'(3);

   localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_X_RESET = OFFSET_WIDTH'(512);
   localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_Y_RESET = OFFSET_WIDTH'(256);
   localparam logic [STEP_WIDTH-1:0] PIXEL_STEP_RESET = STEP_WIDTH'(64'h0000_0010_0000_0000);
   localparam logic [ITER_BITS-1:0]  MAX_ITER_RESET   = ITER_BITS'(1000);

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic [ESC_WIDTH-1:0] ESCAPE_LIMIT = ESC_WIDTH'(1) << (FRAC_BITS + 2);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_X,
      ST_WAIT_X,
      ST_MAP_Y,
      ST_WAIT_Y,
      ST_CHECK,
      ST_MUL_RR,
      ST_WAIT_RR,
      ST_MUL_II,
      ST_WAIT_II,
      ST_MUL_RI,
      ST_WAIT_RI,
      ST_TEST,
      ST_DONE
   } mets_state_type;

   typedef struct packed {
      logic                 start;
      logic [MAG_WIDTH-1:0] a_mag;
      logic [MAG_WIDTH-1:0] b_mag;
   } mul_req_type;

   typedef struct packed {
      logic                  done;
      logic [PROD_WIDTH-1:0] product;
   } mul_rsp_type;

   // signed plane coordinate from a magnitude product, saturated
   function automatic logic signed [COORD_WIDTH-1:0] plane_coord(
      input logic                  neg,
      input logic [PROD_WIDTH-1:0] p
   );
      logic signed [COORD_WIDTH-1:0] v;
      v = $signed({1'b0, p[COORD_WIDTH-2:0]});
      if (p[PROD_WIDTH-1:COORD_WIDTH-1] != '0) begin
         return neg ? COORD_MIN : COORD_MAX;
      end
      return neg ? -v : v;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic [SUM_WIDTH-COORD_WIDTH:0] top;
      top = v[SUM_WIDTH-1:COORD_WIDTH-1];
      if (top != '0 && top != '1) begin
         return v[SUM_WIDTH-1] ? COORD_MIN : COORD_MAX;
      end
      return v[COORD_WIDTH-1:0];
   endfunction

   function automatic logic [RGB_WIDTH-1:0] palette(input logic [ITER_BITS-1:0] n);
      logic [ITER_BITS:0]        m;
      logic [BAND_WIDTH-1:0]     band;
      logic [COLOR_WIDTH-1:0]    lo;
      logic [RGB_WIDTH-1:0]      rgb;
      if ((n >> COLOR_WIDTH) == '0) begin
         m = {n, 1'b0};
      end else begin
         m = (ITER_BITS+1)'(n) + (ITER_BITS+1)'(PAL_BAND);
      end
      band = m[ITER_BITS:COLOR_WIDTH];
      lo   = m[COLOR_WIDTH-1:0];
      unique case (band)
         BAND_WIDTH'(0): rgb = {~lo, {COLOR_WIDTH{1'b0}}, lo};
         BAND_WIDTH'(1): rgb = {lo, ~lo, {COLOR_WIDTH{1'b0}}};
         BAND_WIDTH'(2): rgb = {{COLOR_WIDTH{1'b0}}, lo, ~lo};
         BAND_WIDTH'(3): rgb = {lo, {COLOR_WIDTH{1'b1}}, lo};
         default:        rgb = {RGB_WIDTH{1'b1}};
      endcase
      return rgb;
   endfunction

endpackage

FILE: design/mets_if.sv
// ----------------------------------------------------------------------------
// mets_if
// Valid/ready channel interfaces: pixel requests, responses, register writes.
// ----------------------------------------------------------------------------
interface mets_req_if import mets_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [PIXEL_WIDTH-1:0] pixel_x;
   logic signed [PIXEL_WIDTH-1:0] pixel_y;

   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface mets_rsp_if import mets_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ITER_BITS-1:0] iterations;
   logic                 in_set;
   logic [RGB_WIDTH-1:0] rgb;

   modport source (output valid, iterations, in_set, rgb, input ready);
   modport sink   (input valid, iterations, in_set, rgb, output ready);
endinterface

interface mets_csr_if import mets_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator for one pixel: maps the pixel to the plane, iterates
// z = z*z + c in Q4.44 and returns the count, in-set flag and palette colour.
// ----------------------------------------------------------------------------
// Channel  Dir  Modport  Payload
// req_if   in   sink     pixel_x, pixel_y
// rsp_if   out  source   iterations, in_set, rgb
// csr_if   in   sink     index, data (always ready)
//
// Every multiply runs on the shared half-width multiplier; one iteration is
// a check, three multiplies and an update. A pixel iterates until it escapes
// or reaches the limit. The block is ready for the next request in the cycle
// after the response is loaded; a response still waiting in the output
// register holds the block until it is taken.
// Synchronous reset clears control and loads register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel import mets_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mets_req_if.sink   req_if,
   mets_rsp_if.source rsp_if,
   mets_csr_if.sink   csr_if
);

   mets_state_type state_ff, state_in;

   logic signed [OFFSET_WIDTH-1:0] offset_x_ff, offset_x_in;
   logic signed [OFFSET_WIDTH-1:0] offset_y_ff, offset_y_in;
   logic [STEP_WIDTH-1:0]          pixel_step_ff, pixel_step_in;
   logic [ITER_BITS-1:0]           max_iter_ff, max_iter_in;

   logic signed [PIXEL_WIDTH-1:0]  px_ff, px_in;
   logic signed [PIXEL_WIDTH-1:0]  py_ff, py_in;
   logic signed [COORD_WIDTH-1:0]  cr_ff, cr_in;
   logic signed [COORD_WIDTH-1:0]  ci_ff, ci_in;
   logic signed [COORD_WIDTH-1:0]  zr_ff, zr_in;
   logic signed [COORD_WIDTH-1:0]  zi_ff, zi_in;
   logic [SQ_WIDTH-1:0]            sr_ff, sr_in;
   logic [SQ_WIDTH-1:0]            si_ff, si_in;
   logic signed [CROSS_WIDTH-1:0]  cross_ff, cross_in;
   logic [ITER_BITS-1:0]           iter_ff, iter_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ITER_BITS-1:0]           rsp_iter_ff, rsp_iter_in;
   logic                           rsp_in_set_ff, rsp_in_set_in;
   logic [RGB_WIDTH-1:0]           rsp_rgb_ff, rsp_rgb_in;

   logic signed [DIFF_WIDTH-1:0]   dx;
   logic signed [DIFF_WIDTH-1:0]   dy;
   logic [MAG_WIDTH-1:0]           dx_mag;
   logic [MAG_WIDTH-1:0]           dy_mag;
   logic [MAG_WIDTH-1:0]           zr_mag;
   logic [MAG_WIDTH-1:0]           zi_mag;
   logic [SQ_WIDTH-1:0]            prod_sq;
   logic signed [CROSS_WIDTH-1:0]  prod_signed;
   logic signed [SUM_WIDTH-1:0]    sum_r;
   logic signed [SUM_WIDTH-1:0]    sum_i;
   logic                           escape;
   logic                           in_set;
   logic                           rsp_free;
   logic                           req_accept;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   mets_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // datapath terms
   assign dx     = DIFF_WIDTH'(px_ff) - DIFF_WIDTH'(offset_x_ff);
   assign dy     = DIFF_WIDTH'(py_ff) - DIFF_WIDTH'(offset_y_ff);
   assign dx_mag = dx[DIFF_WIDTH-1] ? MAG_WIDTH'($unsigned(-dx)) : MAG_WIDTH'($unsigned(dx));
   assign dy_mag = dy[DIFF_WIDTH-1] ? MAG_WIDTH'($unsigned(-dy)) : MAG_WIDTH'($unsigned(dy));
   assign zr_mag = zr_ff[COORD_WIDTH-1] ? MAG_WIDTH'($unsigned(-zr_ff))
                                        : MAG_WIDTH'($unsigned(zr_ff));
   assign zi_mag = zi_ff[COORD_WIDTH-1] ? MAG_WIDTH'($unsigned(-zi_ff))
                                        : MAG_WIDTH'($unsigned(zi_ff));

   assign prod_sq     = mul_rsp.product[FRAC_BITS+SQ_WIDTH-1:FRAC_BITS];
   assign prod_signed = (zr_ff[COORD_WIDTH-1] ^ zi_ff[COORD_WIDTH-1])
                        ? -$signed({1'b0, prod_sq}) : $signed({1'b0, prod_sq});

   assign sum_r  = SUM_WIDTH'(sr_ff) - SUM_WIDTH'(si_ff) + SUM_WIDTH'(cr_ff);
   assign sum_i  = (SUM_WIDTH'(cross_ff) <<< 1) + SUM_WIDTH'(ci_ff);
   assign escape = ({1'b0, sr_ff} + {1'b0, si_ff}) > ESCAPE_LIMIT;
   assign in_set = (iter_ff >= max_iter_ff);

   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign req_accept = req_if.valid && req_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_if.valid) state_in = ST_MAP_X;
         ST_MAP_X:   state_in = ST_WAIT_X;
         ST_WAIT_X:  if (mul_rsp.done) state_in = ST_MAP_Y;
         ST_MAP_Y:   state_in = ST_WAIT_Y;
         ST_WAIT_Y:  if (mul_rsp.done) state_in = ST_CHECK;
         ST_CHECK:   state_in = (iter_ff < max_iter_ff) ? ST_MUL_RR : ST_DONE;
         ST_MUL_RR:  state_in = ST_WAIT_RR;
         ST_WAIT_RR: if (mul_rsp.done) state_in = ST_MUL_II;
         ST_MUL_II:  state_in = ST_WAIT_II;
         ST_WAIT_II: if (mul_rsp.done) state_in = ST_MUL_RI;
         ST_MUL_RI:  state_in = ST_WAIT_RI;
         ST_WAIT_RI: if (mul_rsp.done) state_in = ST_TEST;
         ST_TEST:    state_in = escape ? ST_DONE : ST_CHECK;
         ST_DONE:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_if.ready  = 1'b0;
      mul_req.start = 1'b0;
      mul_req.a_mag = zr_mag;
      mul_req.b_mag = zr_mag;
      unique case (state_ff)
         ST_IDLE:  req_if.ready = 1'b1;
         ST_MAP_X: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = dx_mag;
            mul_req.b_mag = MAG_WIDTH'(pixel_step_ff);
         end
         ST_MAP_Y: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = dy_mag;
            mul_req.b_mag = MAG_WIDTH'(pixel_step_ff);
         end
         ST_MUL_RR: mul_req.start = 1'b1;
         ST_MUL_II: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = zi_mag;
            mul_req.b_mag = zi_mag;
         end
         ST_MUL_RI: begin
            mul_req.start = 1'b1;
            mul_req.b_mag = zi_mag;
         end
         default: ;
      endcase
   end

   // config registers
   always_comb begin
      offset_x_in   = offset_x_ff;
      offset_y_in   = offset_y_ff;
      pixel_step_in = pixel_step_ff;
      max_iter_in   = max_iter_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_OFFSET_X:       offset_x_in   = csr_if.data[OFFSET_WIDTH-1:0];
            CSR_OFFSET_Y:       offset_y_in   = csr_if.data[OFFSET_WIDTH-1:0];
            CSR_PIXEL_STEP:     pixel_step_in = csr_if.data[STEP_WIDTH-1:0];
            CSR_MAX_ITERATIONS: max_iter_in   = csr_if.data[ITER_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign csr_if.ready = 1'b1;

   // datapath registers
   always_comb begin
      px_in         = px_ff;
      py_in         = py_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      sr_in         = sr_ff;
      si_in         = si_ff;
      cross_in      = cross_ff;
      iter_in       = iter_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_iter_in   = rsp_iter_ff;
      rsp_in_set_in = rsp_in_set_ff;
      rsp_rgb_in    = rsp_rgb_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               px_in   = req_if.pixel_x;
               py_in   = req_if.pixel_y;
               zr_in   = '0;
               zi_in   = '0;
               iter_in = '0;
            end
         end
         ST_WAIT_X:  if (mul_rsp.done) cr_in = plane_coord(dx[DIFF_WIDTH-1], mul_rsp.product);
         ST_WAIT_Y:  if (mul_rsp.done) ci_in = plane_coord(dy[DIFF_WIDTH-1], mul_rsp.product);
         ST_WAIT_RR: if (mul_rsp.done) sr_in = prod_sq;
         ST_WAIT_II: if (mul_rsp.done) si_in = prod_sq;
         ST_WAIT_RI: if (mul_rsp.done) cross_in = prod_signed;
         ST_TEST: begin
            if (!escape) begin
               zr_in   = sat_coord(sum_r);
               zi_in   = sat_coord(sum_i);
               iter_in = iter_ff + ITER_BITS'(1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_iter_in   = iter_ff;
               rsp_in_set_in = in_set;
               rsp_rgb_in    = in_set ? '0 : palette(iter_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         offset_x_ff   <= OFFSET_X_RESET;
         offset_y_ff   <= OFFSET_Y_RESET;
         pixel_step_ff <= PIXEL_STEP_RESET;
         max_iter_ff   <= MAX_ITER_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         offset_x_ff   <= offset_x_in;
         offset_y_ff   <= offset_y_in;
         pixel_step_ff <= pixel_step_in;
         max_iter_ff   <= max_iter_in;
      end
      px_ff         <= px_in;
      py_ff         <= py_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      sr_ff         <= sr_in;
      si_ff         <= si_in;
      cross_ff      <= cross_in;
      iter_ff       <= iter_in;
      rsp_iter_ff   <= rsp_iter_in;
      rsp_in_set_ff <= rsp_in_set_in;
      rsp_rgb_ff    <= rsp_rgb_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.iterations = rsp_iter_ff;
   assign rsp_if.in_set     = rsp_in_set_ff;
   assign rsp_if.rgb        = rsp_rgb_ff;

endmodule

FILE: design/mets_mul.sv
// ----------------------------------------------------------------------------
// mets_mul
// Multi-cycle unsigned multiplier: one half-width multiplier, four partial
// products, registered accumulate.
// ----------------------------------------------------------------------------
module mets_mul import mets_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [MAG_WIDTH-1:0]       a_ff, a_in;
   logic [MAG_WIDTH-1:0]       b_ff, b_in;
   logic [MUL_STEP_WIDTH-1:0]  step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [PP_WIDTH-1:0]        pp_ff, pp_in;
   logic                       pp_valid_ff, pp_valid_in;
   logic [SHIFT_SEL_WIDTH-1:0] sh_ff, sh_in;
   logic [PROD_WIDTH-1:0]      acc_ff, acc_in;
   logic [CHUNK_WIDTH-1:0]     a_sel;
   logic [CHUNK_WIDTH-1:0]     b_sel;

   assign a_sel = step_ff[1] ? a_ff[MAG_WIDTH-1:CHUNK_WIDTH] : a_ff[CHUNK_WIDTH-1:0];
   assign b_sel = step_ff[0] ? b_ff[MAG_WIDTH-1:CHUNK_WIDTH] : b_ff[CHUNK_WIDTH-1:0];

   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      step_in     = step_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      pp_in       = pp_ff;
      pp_valid_in = 1'b0;
      sh_in       = sh_ff;
      acc_in      = acc_ff;
      if (pp_valid_ff) begin
         acc_in = acc_ff + (PROD_WIDTH'(pp_ff) << (CHUNK_WIDTH * sh_ff));
      end
      if (req.start) begin
         a_in    = req.a_mag;
         b_in    = req.b_mag;
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == MUL_STEP_WIDTH'(MUL_STEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            pp_in       = a_sel * b_sel;
            sh_in       = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
            pp_valid_in = 1'b1;
            step_in     = step_ff + MUL_STEP_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         busy_ff     <= 1'b0;
         done_ff     <= 1'b0;
         pp_valid_ff <= 1'b0;
      end else begin
         step_ff     <= step_in;
         busy_ff     <= busy_in;
         done_ff     <= done_in;
         pp_valid_ff <= pp_valid_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

FILE: verif/escape_time_checker.sv
// ----------------------------------------------------------------------------
// escape_time_checker
// Passive checker for the escape-time pixel evaluator. It follows register
// writes, predicts the count, in-set flag and colour of every accepted pixel
// request in Q4.44 arithmetic, and compares each accepted response field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module escape_time_checker import mets_pkg::*; (
   input  logic clock,
   input  logic reset,
   mets_req_if  req,
   mets_rsp_if  rsp,
   mets_csr_if  csr,
   output int   results_due,
   output int   mismatches
);

   typedef struct packed {
      logic [ITER_BITS-1:0] iterations;
      logic                 in_set;
      logic [RGB_WIDTH-1:0] rgb;
   } pixel_result_type;

   localparam longint COORD_LIM    = longint'(1) << (COORD_WIDTH - 1);
   localparam longint ESCAPE_BOUND = longint'(4) << FRAC_BITS;

   logic signed [OFFSET_WIDTH-1:0] view_offset_x;
   logic signed [OFFSET_WIDTH-1:0] view_offset_y;
   logic [STEP_WIDTH-1:0]          view_step;
   logic [ITER_BITS-1:0]           iter_limit;
   pixel_result_type               results_pending[$];
   pixel_result_type               want;
   int                             responses_seen;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic longint clamp_coord(input longint v);
      if (v < -COORD_LIM) begin
         return -COORD_LIM;
      end
      if (v > COORD_LIM - 1) begin
         return COORD_LIM - 1;
      end
      return v;
   endfunction

   // exact product of magnitudes, truncated toward zero, sign applied after
   function automatic longint scaled_mul(input longint a, input longint b);
      logic [COORD_WIDTH-1:0]   ma;
      logic [COORD_WIDTH-1:0]   mb;
      logic [2*COORD_WIDTH-1:0] p;
      logic [63:0]              q;
      ma = (a < 0) ? COORD_WIDTH'(-a) : COORD_WIDTH'(a);
      mb = (b < 0) ? COORD_WIDTH'(-b) : COORD_WIDTH'(b);
      p  = ma * mb;
      q  = 64'(p >> FRAC_BITS);
      return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint plane_coord_of(
      input logic signed [PIXEL_WIDTH-1:0]  pix,
      input logic signed [OFFSET_WIDTH-1:0] off
   );
      longint      d;
      logic [33:0] mag;
      logic [79:0] prod;
      d    = longint'(pix) - longint'(off);
      mag  = (d < 0) ? 34'(-d) : 34'(d);
      prod = mag * view_step;
      if (d < 0) begin
         return (prod >= COORD_LIM) ? -COORD_LIM : -longint'(prod);
      end
      return (prod >= COORD_LIM) ? COORD_LIM - 1 : longint'(prod);
   endfunction

   function automatic logic [RGB_WIDTH-1:0] palette_color(input int n);
      int       m;
      bit [7:0] red;
      bit [7:0] grn;
      bit [7:0] blu;
      m = (n < 256) ? 2 * n : n + 256;
      if (m < 256) begin
         red = 8'(255 - m);
         grn = 8'd0;
         blu = 8'(m);
      end else if (m < 512) begin
         red = 8'(m - 256);
         grn = 8'(511 - m);
         blu = 8'd0;
      end else if (m < 768) begin
         red = 8'd0;
         grn = 8'(m - 512);
         blu = 8'(767 - m);
      end else if (m < 1024) begin
         red = 8'(m - 768);
         grn = 8'd255;
         blu = red;
      end else begin
         red = 8'd255;
         grn = 8'd255;
         blu = 8'd255;
      end
      return {red, grn, blu};
   endfunction

   function automatic pixel_result_type escape_result(
      input logic signed [PIXEL_WIDTH-1:0] px,
      input logic signed [PIXEL_WIDTH-1:0] py
   );
      longint           cr;
      longint           ci;
      longint           zr;
      longint           zi;
      longint           rr;
      longint           ii;
      longint           ri;
      int               n;
      pixel_result_type res;
      cr = plane_coord_of(px, view_offset_x);
      ci = plane_coord_of(py, view_offset_y);
      zr = 0;
      zi = 0;
      n  = 0;
      while (n < iter_limit) begin
         rr = scaled_mul(zr, zr);
         ii = scaled_mul(zi, zi);
         if (rr + ii > ESCAPE_BOUND) begin
            break;
         end
         ri = scaled_mul(zr, zi);
         zr = clamp_coord(rr - ii + cr);
         zi = clamp_coord(2 * ri + ci);
         n++;
      end
      res.iterations = ITER_BITS'(n);
      res.in_set     = (n >= iter_limit);
      res.rgb        = res.in_set ? '0 : palette_color(n);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         view_offset_x  = OFFSET_X_RESET;
         view_offset_y  = OFFSET_Y_RESET;
         view_step      = PIXEL_STEP_RESET;
         iter_limit     = MAX_ITER_RESET;
         responses_seen = 0;
         results_pending.delete();
      end else begin
         if (csr.valid === 1'b1 && csr.ready === 1'b1) begin
            unique case (csr.index)
               CSR_OFFSET_X:       view_offset_x = csr.data[OFFSET_WIDTH-1:0];
               CSR_OFFSET_Y:       view_offset_y = csr.data[OFFSET_WIDTH-1:0];
               CSR_PIXEL_STEP:     view_step     = csr.data[STEP_WIDTH-1:0];
               CSR_MAX_ITERATIONS: iter_limit    = csr.data[ITER_BITS-1:0];
               default: ;
            endcase
         end
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            results_pending.push_back(escape_result(req.pixel_x, req.pixel_y));
         end
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            responses_seen++;
            if (results_pending.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request outstanding",
                                         responses_seen));
            end else begin
               want = results_pending.pop_front();
               if (rsp.iterations !== want.iterations) begin
                  report_mismatch($sformatf("response %0d iterations %0d, expected %0d",
                                            responses_seen, rsp.iterations,
                                            want.iterations));
               end
               if (rsp.in_set !== want.in_set) begin
                  report_mismatch($sformatf("response %0d in_set %b, expected %b",
                                            responses_seen, rsp.in_set, want.in_set));
               end
               if (rsp.rgb !== want.rgb) begin
                  report_mismatch($sformatf("response %0d rgb %06h, expected %06h",
                                            responses_seen, rsp.rgb, want.rgb));
               end
            end
         end
      end
      results_due = results_pending.size();
   end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the escape-time pixel evaluator. Directed views cover the
// field and register extremes, saturated plane points, slow escapes near the
// boundary for every palette band, a zero step, a zero limit and writes to
// unused register indexes. Random views then scan small windows of the plane
// with random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb import mets_pkg::*; ();

   localparam int WATCHDOG_CYCLES = 500000;
   localparam int HOLD_CYCLES     = 3000;
   localparam int DRAIN_CYCLES    = 1000;
   localparam int SCENES          = 6;
   localparam int SCENE_PIXELS    = 96;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LOW = CSR_INDEX_WIDTH'(4);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_TOP = '1;

   localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_MIN = 32'sh8000_0000;
   localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_MAX = 32'sh7FFF_FFFF;

   logic clock;
   logic reset;
   logic hold_rsp;
   bit   sender_burst;
   int   results_due;
   int   mismatches;
   int   quiet_cycles;

   mets_req_if req_ch();
   mets_rsp_if rsp_ch();
   mets_csr_if csr_ch();

   mandelbrot_escape_time_pixel u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   escape_time_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr         (csr_ch),
      .results_due (results_due),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0]  value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
   endtask

   // upper data bits beyond each register's width are filled with noise
   task automatic program_view(input logic signed [OFFSET_WIDTH-1:0] ox,
                               input logic signed [OFFSET_WIDTH-1:0] oy,
                               input logic [STEP_WIDTH-1:0]          step,
                               input logic [ITER_BITS-1:0]           limit,
                               input bit                             stray);
      csr_write(CSR_OFFSET_X, {13'($urandom), ox});
      csr_write(CSR_OFFSET_Y, {13'($urandom), oy});
      csr_write(CSR_PIXEL_STEP, step);
      csr_write(CSR_MAX_ITERATIONS, {33'({$urandom, $urandom}), limit});
      if (stray) begin
         csr_write(CSR_UNUSED_LOW, CSR_DATA_WIDTH'({$urandom, $urandom}));
         csr_write(CSR_UNUSED_TOP, CSR_DATA_WIDTH'({$urandom, $urandom}));
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_pixel(input logic signed [PIXEL_WIDTH-1:0] px,
                             input logic signed [PIXEL_WIDTH-1:0] py);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.pixel_x <= px;
      req_ch.pixel_y <= py;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   // response side: random stalls, bursts, and one long hold-off
   initial begin
      int gap;
      int taken;
      bit held;
      taken = 0;
      held  = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_rsp && !held) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end else if ((taken / 40) % 3 == 2) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 12);
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         taken++;
      end
   end

   initial begin
      int                             k;
      int                             r;
      logic signed [OFFSET_WIDTH-1:0] ox;
      logic signed [OFFSET_WIDTH-1:0] oy;
      reset          <= 1'b1;
      hold_rsp       <= 1'b0;
      sender_burst    = 1'b0;
      req_ch.valid   <= 1'b0;
      req_ch.pixel_x <= '0;
      req_ch.pixel_y <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= '0;
      csr_ch.data    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset view: corners saturate, center pixel runs to the limit
      send_pixel(16'sh8000, 16'sh8000);
      send_pixel(16'sh7FFF, 16'sh7FFF);
      send_pixel(16'sh8000, 16'sh7FFF);
      send_pixel(16'sh7FFF, 16'sh8000);
      send_pixel(16'sd512, 16'sd256);
      send_pixel(16'sd0, 16'sd0);
      wait_idle();

      // near c = -0.75: slow escapes reach every palette band, then full limit
      program_view(32'sd768, 32'sd0, STEP_WIDTH'(1) << (FRAC_BITS - 10), '1, 1'b0);
      send_pixel(16'sd0, 16'sd20);
      send_pixel(16'sd0, -16'sd8);
      send_pixel(16'sd0, 16'sd5);
      send_pixel(16'sd0, -16'sd3);
      send_pixel(16'sd0, 16'sd0);
      wait_idle();

      program_view(OFFSET_MIN, OFFSET_MAX, STEP_WIDTH'(1) << FRAC_BITS, ITER_BITS'(1), 1'b0);
      send_pixel(16'sh8000, 16'sh8000);
      send_pixel(16'sh7FFF, 16'sh7FFF);
      send_pixel(16'sd0, 16'sd0);
      wait_idle();

      program_view(32'sd0, 32'sd0, '1, ITER_BITS'(2), 1'b0);
      send_pixel(16'sd0, 16'sd0);
      send_pixel(16'sd1, -16'sd1);
      send_pixel(-16'sd1, 16'sd0);
      wait_idle();

      program_view(OFFSET_MAX, OFFSET_MIN, STEP_WIDTH'(1), ITER_BITS'(3), 1'b0);
      send_pixel(16'sh8000, 16'sh7FFF);
      send_pixel(16'sh7FFF, 16'sh8000);
      wait_idle();

      // zero step: everything maps to the origin
      program_view(32'sd5, -32'sd7, '0, ITER_BITS'(6), 1'b0);
      send_pixel(16'sd100, -16'sd200);
      send_pixel(16'sh8000, 16'sh7FFF);
      wait_idle();

      // zero limit, plus writes to unused indexes that must change nothing
      program_view(OFFSET_X_RESET, OFFSET_Y_RESET, PIXEL_STEP_RESET, '0, 1'b1);
      send_pixel(16'sd512, 16'sd256);
      send_pixel(16'sd0, 16'sd0);
      wait_idle();

      for (int s = 0; s < SCENES; s++) begin
         k            = $urandom_range(4, 9);
         ox           = int'($urandom_range(0, 4000)) - 2000;
         oy           = int'($urandom_range(0, 4000)) - 2000;
         sender_burst = ($urandom_range(0, 2) == 0);
         program_view(ox, oy, STEP_WIDTH'(1) << (FRAC_BITS - k),
                      ITER_BITS'($urandom_range(1, 40)), 1'b0);
         if (s == 0) begin
            hold_rsp    <= 1'b1;
            sender_burst = 1'b1;
         end
         r = 5 << (k - 1);
         repeat (SCENE_PIXELS) begin
            if ($urandom_range(0, 19) < 3) begin
               send_pixel(16'($urandom), 16'($urandom));
            end else begin
               send_pixel(16'(int'(ox) + int'($urandom_range(0, 2 * r)) - r),
                          16'(int'(oy) + int'($urandom_range(0, 2 * r)) - r));
            end
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/mets_pkg.sv
design/mets_if.sv
design/mets_mul.sv
design/mandelbrot_escape_time_pixel.sv
verif/escape_time_checker.sv
verif/tb.sv
